### hw/rtl/aarm_pkg.sv
// shared constants and fixed-point helpers for the axis-angle rotation matrix unit
package aarm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int XW               = 34;
    localparam int ZW               = 34;
    localparam int LW               = 30;
    localparam int RW               = 62;
    localparam int DW               = 52;
    localparam int QW               = 22;
    localparam int UW               = 22;
    localparam int PW               = 23;
    localparam int SQRT_CELLS       = LW;
    localparam int DIV_CELLS        = QW;
    localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);
    localparam logic [QW-1:0]        ONE20     = QW'(1 << 20);

    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(536870912);
            1:       v = ZW'(316933406);
            2:       v = ZW'(167458907);
            3:       v = ZW'(85004756);
            4:       v = ZW'(42667331);
            5:       v = ZW'(21354465);
            6:       v = ZW'(10679838);
            7:       v = ZW'(5340245);
            8:       v = ZW'(2670163);
            9:       v = ZW'(1335087);
            10:      v = ZW'(667544);
            11:      v = ZW'(333772);
            12:      v = ZW'(166886);
            13:      v = ZW'(83443);
            14:      v = ZW'(41722);
            15:      v = ZW'(20861);
            16:      v = ZW'(10430);
            17:      v = ZW'(5215);
            18:      v = ZW'(2608);
            19:      v = ZW'(1304);
            20:      v = ZW'(652);
            21:      v = ZW'(326);
            22:      v = ZW'(163);
            23:      v = ZW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to nearest, halves away from zero
    function automatic logic signed [27:0] rnd_sh20(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] r;
        mag = v[47] ? 48'(-v) : 48'(v);
        r   = (mag + 48'(1 << 19)) >> 20;
        return v[47] ? 28'(-r[27:0]) : r[27:0];
    endfunction

    function automatic logic signed [23:0] rnd_sh10(input logic signed [XW-1:0] v);
        logic [XW-1:0] mag;
        logic [XW-1:0] r;
        mag = v[XW-1] ? XW'(-v) : XW'(v);
        r   = (mag + XW'(1 << 9)) >> 10;
        return v[XW-1] ? 24'(-r[23:0]) : r[23:0];
    endfunction

    function automatic logic [15:0] to_q14(input logic signed [24:0] v);
        logic [24:0]        mag;
        logic [24:0]        r;
        logic signed [19:0] q;
        mag = v[24] ? 25'(-v) : 25'(v);
        r   = (mag + 25'(32)) >> 6;
        q   = v[24] ? 20'(-r[19:0]) : r[19:0];
        if (q > 20'sd16384) begin
            q = 20'sd16384;
        end else if (q < -20'sd16384) begin
            q = -20'sd16384;
        end
        return q[15:0];
    endfunction

endpackage

### hw/rtl/aarm_sqrt_cell.sv
// one bit of the pipelined square root of the squared axis length
module aarm_sqrt_cell #(
    parameter int BIT = 0,
    parameter int SW  = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [aarm_pkg::RW-1:0]  i_rem,
    input  logic [aarm_pkg::LW-1:0]  i_root,
    input  logic [SW-1:0]            i_side,
    output logic                     o_valid,
    output logic [aarm_pkg::RW-1:0]  o_rem,
    output logic [aarm_pkg::LW-1:0]  o_root,
    output logic [SW-1:0]            o_side
);
    import aarm_pkg::*;

    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] n_rem;
    logic [LW-1:0] n_root;
    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [LW-1:0] r_root;
    logic [SW-1:0] r_side;

    always_comb begin
        trial  = (RW'(i_root) << (BIT + 1)) + (RW'(1) << (2 * BIT));
        ge     = i_rem >= trial;
        n_rem  = ge ? i_rem - trial : i_rem;
        n_root = ge ? (i_root | (LW'(1) << BIT)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

### hw/rtl/aarm_div_cell.sv
// one quotient bit of the three pipelined axis normalizing divisions
module aarm_div_cell #(
    parameter int BIT = 0,
    parameter int SW  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [aarm_pkg::LW-1:0]       i_len,
    input  logic [2:0][aarm_pkg::DW-1:0]  i_rem,
    input  logic [2:0][aarm_pkg::QW-1:0]  i_quo,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [aarm_pkg::LW-1:0]       o_len,
    output logic [2:0][aarm_pkg::DW-1:0]  o_rem,
    output logic [2:0][aarm_pkg::QW-1:0]  o_quo,
    output logic [SW-1:0]                 o_side
);
    import aarm_pkg::*;

    logic [DW-1:0]         trial;
    logic [2:0][DW-1:0]    n_rem;
    logic [2:0][QW-1:0]    n_quo;
    logic                  r_valid;
    logic [LW-1:0]         r_len;
    logic [2:0][DW-1:0]    r_rem;
    logic [2:0][QW-1:0]    r_quo;
    logic [SW-1:0]         r_side;

    always_comb begin
        trial = DW'(i_len) << BIT;
        for (int k = 0; k < 3; k++) begin
            if (i_rem[k] >= trial) begin
                n_rem[k] = i_rem[k] - trial;
                n_quo[k] = i_quo[k] | (QW'(1) << BIT);
            end else begin
                n_rem[k] = i_rem[k];
                n_quo[k] = i_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= i_len;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

### hw/rtl/aarm_cordic_cell.sv
// one rotation-mode cordic iteration
module aarm_cordic_cell #(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [aarm_pkg::XW-1:0]  i_x,
    input  logic signed [aarm_pkg::XW-1:0]  i_y,
    input  logic signed [aarm_pkg::ZW-1:0]  i_z,
    input  logic [SW-1:0]                   i_side,
    output logic                            o_valid,
    output logic signed [aarm_pkg::XW-1:0]  o_x,
    output logic signed [aarm_pkg::XW-1:0]  o_y,
    output logic signed [aarm_pkg::ZW-1:0]  o_z,
    output logic [SW-1:0]                   o_side
);
    import aarm_pkg::*;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_side;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (!i_z[ZW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - atan_turn(STEP);
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + atan_turn(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

### hw/rtl/axis_angle_rotation_matrix_unit.sv
// top level of the axis-angle to 3x3 rotation matrix stream unit
//
// input stream s_axis carries one axis (x, y, z) and a turn angle per transfer;
// output stream m_axis carries the nine q1.14 matrix elements per transfer,
// with tuser high when the axis had zero length and the identity was sent.
// the unit is a single pipeline of cells: squared length, 30 square-root
// cells (one root bit each), 22 divider cells (one quotient bit each for all
// three components), a unit vector clamp and angle fold stage,
// CORDIC_STEPS cordic cells, then sine and cosine rounding, first products,
// one-minus-cosine scaling and the output register.
// one transfer per cycle unless the receiver stalls; every stage holds one item.
// when the receiver stalls the whole pipeline holds and s_axis_tready drops
// only while a result waits at the output register; a free output slot lets
// the pipeline move on, and bubbles already in the pipeline keep their place.
// reset empties the pipeline; no result is pending after it.
module axis_angle_rotation_matrix_unit #(
    parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,   // axis_x, axis_y, axis_z, turn_angle
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output logic          m_axis_tuser    // zero_axis
);
    import aarm_pkg::*;

    localparam int SSW = 65;
    localparam int DSW = 20;
    localparam int CSW = 3 * UW + 2;

    logic en;

    // squared length stage
    logic                 r0_valid;
    logic [31:0]          r0_len2;
    logic [63:0]          r0_side;
    logic signed [15:0]   in_x;
    logic signed [15:0]   in_y;
    logic signed [15:0]   in_z;
    logic [31:0]          n0_len2;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        in_x    = s_axis_tdata[15:0];
        in_y    = s_axis_tdata[31:16];
        in_z    = s_axis_tdata[47:32];
        n0_len2 = 32'(in_x) * 32'(in_x) + 32'(in_y) * 32'(in_y) + 32'(in_z) * 32'(in_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_len2 <= n0_len2;
            r0_side <= s_axis_tdata;
        end
    end

    // square root chain
    logic          sq_valid [0:SQRT_CELLS];
    logic [RW-1:0] sq_rem   [0:SQRT_CELLS];
    logic [LW-1:0] sq_root  [0:SQRT_CELLS];
    logic [SSW-1:0] sq_side [0:SQRT_CELLS];

    assign sq_valid[0] = r0_valid;
    assign sq_rem[0]   = {r0_len2, 30'd0} >> 2;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {(r0_len2 == 32'd0), r0_side};

    for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
        aarm_sqrt_cell #(
            .BIT (SQRT_CELLS - 1 - i),
            .SW  (SSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[i]),
            .i_rem   (sq_rem[i]),
            .i_root  (sq_root[i]),
            .i_side  (sq_side[i]),
            .o_valid (sq_valid[i+1]),
            .o_rem   (sq_rem[i+1]),
            .o_root  (sq_root[i+1]),
            .o_side  (sq_side[i+1])
        );
    end

    // divider chain
    logic               dv_valid [0:DIV_CELLS];
    logic [LW-1:0]      dv_len   [0:DIV_CELLS];
    logic [2:0][DW-1:0] dv_rem   [0:DIV_CELLS];
    logic [2:0][QW-1:0] dv_quo   [0:DIV_CELLS];
    logic [DSW-1:0]     dv_side  [0:DIV_CELLS];
    logic [SSW-1:0]     sq_out;
    logic [2:0]         sgn;
    logic [2:0][16:0]   mag;
    logic [2:0][DW-1:0] dv_in;

    always_comb begin
        sq_out = sq_side[SQRT_CELLS];
        for (int k = 0; k < 3; k++) begin
            sgn[k] = sq_out[16*k+15];
            mag[k] = sgn[k] ? 17'(-{1'b1, sq_out[16*k +: 16]})
                            : {1'b0, sq_out[16*k +: 16]};
            dv_in[k] = (DW'(mag[k]) << 34) + DW'(sq_root[SQRT_CELLS] >> 1);
        end
    end

    assign dv_rem[0]   = dv_in;
    assign dv_valid[0] = sq_valid[SQRT_CELLS];
    assign dv_len[0]   = sq_root[SQRT_CELLS];
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = {sq_out[64], sq_out[63:48], sgn};

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
        aarm_div_cell #(
            .BIT (DIV_CELLS - 1 - i),
            .SW  (DSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[i]),
            .i_len   (dv_len[i]),
            .i_rem   (dv_rem[i]),
            .i_quo   (dv_quo[i]),
            .i_side  (dv_side[i]),
            .o_valid (dv_valid[i+1]),
            .o_len   (dv_len[i+1]),
            .o_rem   (dv_rem[i+1]),
            .o_quo   (dv_quo[i+1]),
            .o_side  (dv_side[i+1])
        );
    end

    // unit vector clamp and angle fold
    logic                 ru_valid;
    logic signed [XW-1:0] ru_x;
    logic signed [ZW-1:0] ru_z;
    logic [CSW-1:0]       ru_side;
    logic [DSW-1:0]       dv_out;
    logic [15:0]          ang;
    logic                 flip;
    logic signed [17:0]   ang_f;
    logic [2:0][UW-1:0]   n_u;
    logic [QW-1:0]        qc;

    always_comb begin
        dv_out = dv_side[DIV_CELLS];
        ang    = dv_out[18:3];
        flip   = ang[15] ^ ang[14];
        if (flip) begin
            ang_f = 18'({2'b00, ang}) - 18'sd32768;
        end else if (ang[15]) begin
            ang_f = 18'({2'b00, ang}) - 18'sd65536;
        end else begin
            ang_f = 18'({2'b00, ang});
        end
        for (int k = 0; k < 3; k++) begin
            qc     = (dv_quo[DIV_CELLS][k] > ONE20) ? ONE20 : dv_quo[DIV_CELLS][k];
            n_u[k] = dv_out[k] ? UW'(-qc) : UW'(qc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ru_valid <= 1'b0;
        end else if (en) begin
            ru_valid <= dv_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ru_x    <= CORDIC_X0;
            ru_z    <= ZW'(ang_f) <<< 16;
            ru_side <= {flip, dv_out[19], n_u[2], n_u[1], n_u[0]};
        end
    end

    // cordic chain
    logic                 cd_valid [0:CORDIC_STEPS];
    logic signed [XW-1:0] cd_x     [0:CORDIC_STEPS];
    logic signed [XW-1:0] cd_y     [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cd_z     [0:CORDIC_STEPS];
    logic [CSW-1:0]       cd_side  [0:CORDIC_STEPS];

    assign cd_valid[0] = ru_valid;
    assign cd_x[0]     = ru_x;
    assign cd_y[0]     = '0;
    assign cd_z[0]     = ru_z;
    assign cd_side[0]  = ru_side;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        aarm_cordic_cell #(
            .STEP (i),
            .SW   (CSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cd_valid[i]),
            .i_x     (cd_x[i]),
            .i_y     (cd_y[i]),
            .i_z     (cd_z[i]),
            .i_side  (cd_side[i]),
            .o_valid (cd_valid[i+1]),
            .o_x     (cd_x[i+1]),
            .o_y     (cd_y[i+1]),
            .o_z     (cd_z[i+1]),
            .o_side  (cd_side[i+1])
        );
    end

    // sine and cosine rounding
    logic                 rr_valid;
    logic signed [UW-1:0] rr_c;
    logic signed [UW-1:0] rr_s;
    logic signed [PW-1:0] rr_t;
    logic signed [UW-1:0] rr_ux;
    logic signed [UW-1:0] rr_uy;
    logic signed [UW-1:0] rr_uz;
    logic                 rr_zero;
    logic [CSW-1:0]       cd_out;
    logic signed [XW-1:0] xf;
    logic signed [XW-1:0] yf;
    logic signed [23:0]   c24;
    logic signed [23:0]   s24;

    always_comb begin
        cd_out = cd_side[CORDIC_STEPS];
        xf     = cd_out[CSW-1] ? -cd_x[CORDIC_STEPS] : cd_x[CORDIC_STEPS];
        yf     = cd_out[CSW-1] ? -cd_y[CORDIC_STEPS] : cd_y[CORDIC_STEPS];
        c24    = rnd_sh10(xf);
        s24    = rnd_sh10(yf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rr_valid <= 1'b0;
        end else if (en) begin
            rr_valid <= cd_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rr_c    <= c24[UW-1:0];
            rr_s    <= s24[UW-1:0];
            rr_t    <= PW'(ONE20) - PW'(c24);
            rr_ux   <= cd_out[UW-1:0];
            rr_uy   <= cd_out[2*UW-1:UW];
            rr_uz   <= cd_out[3*UW-1:2*UW];
            rr_zero <= cd_out[3*UW];
        end
    end

    // first products
    logic                   r1_valid;
    logic signed [UW-1:0]   r1_c;
    logic signed [PW-1:0]   r1_t;
    logic                   r1_zero;
    logic signed [PW-1:0]   r1_p [0:8];
    logic signed [2*UW-1:0] pr1  [0:8];

    always_comb begin
        pr1[0] = rr_ux * rr_ux;
        pr1[1] = rr_uy * rr_uy;
        pr1[2] = rr_uz * rr_uz;
        pr1[3] = rr_ux * rr_uy;
        pr1[4] = rr_ux * rr_uz;
        pr1[5] = rr_uy * rr_uz;
        pr1[6] = rr_s * rr_ux;
        pr1[7] = rr_s * rr_uy;
        pr1[8] = rr_s * rr_uz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= rr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c    <= rr_c;
            r1_t    <= rr_t;
            r1_zero <= rr_zero;
            for (int k = 0; k < 9; k++) begin
                r1_p[k] <= PW'(rnd_sh20(48'(pr1[k])));
            end
        end
    end

    // scaling by one minus cosine
    logic                   r2_valid;
    logic signed [UW-1:0]   r2_c;
    logic                   r2_zero;
    logic signed [PW-1:0]   r2_p [0:8];
    logic signed [2*PW-1:0] pr2  [0:5];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            pr2[k] = r1_t * r1_p[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c    <= r1_c;
            r2_zero <= r1_zero;
            for (int k = 0; k < 6; k++) begin
                r2_p[k] <= PW'(rnd_sh20(48'(pr2[k])));
            end
            for (int k = 6; k < 9; k++) begin
                r2_p[k] <= r1_p[k];
            end
        end
    end

    // sums, q1.14 rounding and output register
    logic                 r_out_valid;
    logic [143:0]         r_out_data;
    logic                 r_out_zero;
    logic signed [24:0]   sm [0:8];
    logic [143:0]         n_out_data;

    always_comb begin
        sm[0] = 25'(r2_c) + 25'(r2_p[0]);
        sm[1] = 25'(r2_p[3]) + 25'(r2_p[8]);
        sm[2] = 25'(r2_p[4]) - 25'(r2_p[7]);
        sm[3] = 25'(r2_p[3]) - 25'(r2_p[8]);
        sm[4] = 25'(r2_c) + 25'(r2_p[1]);
        sm[5] = 25'(r2_p[5]) + 25'(r2_p[6]);
        sm[6] = 25'(r2_p[4]) + 25'(r2_p[7]);
        sm[7] = 25'(r2_p[5]) - 25'(r2_p[6]);
        sm[8] = 25'(r2_c) + 25'(r2_p[2]);
        for (int k = 0; k < 9; k++) begin
            if (r2_zero) begin
                n_out_data[16*k +: 16] = (k == 0 || k == 4 || k == 8) ? 16'd16384 : 16'd0;
            end else begin
                n_out_data[16*k +: 16] = to_q14(sm[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_zero <= r2_zero;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_zero;

endmodule
